FILE: rtl/gcne_pkg.sv
// Package for the grid cell neighbor enumerator.
// Holds field widths, register indexes and the types shared by the front,
// the job queue and the back. No dependencies.
package gcne_pkg;

    // Field and datapath widths
    localparam int ID_W       = 18;
    localparam int SIDE_W     = 7;
    localparam int PLANE_W    = 2 * SIDE_W;
    localparam int VOL_W      = 3 * SIDE_W;
    localparam int DIR_W      = 3;
    localparam int NUM_DIR    = 6;
    localparam int DIV_W      = PLANE_W + SIDE_W - 1;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = SIDE_W;
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_THREE_DIM   = 1'b1;

    // Reset values of the registers
    localparam logic [SIDE_W-1:0] RST_SIDE_LENGTH = 7'd8;
    localparam logic              RST_THREE_DIM   = 1'b0;

    // Job queue depth (power of two)
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    // Grid shape as seen by the front
    typedef struct packed {
        logic              three;
        logic [SIDE_W-1:0] side;
    } t_cfg;

    // One classified cell, handed from front to back
    typedef struct packed {
        logic [ID_W-1:0]    rid;
        logic [SIDE_W-1:0]  side;
        logic [PLANE_W-1:0] plane;
        logic               three;
        logic               inr;
        logic [SIDE_W-1:0]  c0;
        logic [SIDE_W-1:0]  c1;
        logic [SIDE_W-1:0]  c2;
    } t_job;

endpackage

FILE: rtl/gcne_front.sv
// Front of the neighbor enumerator: accepts a cell index, range checks it and
// splits it into coordinates with a restoring divider (quotient bits 6..3, then 2..0).
// Depends on gcne_pkg.
module gcne_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  gcne_pkg::t_cfg             i_cfg,
    input  logic                       i_valid,
    input  logic [gcne_pkg::ID_W-1:0]  i_region_id,
    output logic                       o_stall,
    output logic                       o_push,
    output gcne_pkg::t_job             o_job,
    input  logic                       i_full
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_D1H  = 3'd2;
    localparam logic [2:0] ST_D1L  = 3'd3;
    localparam logic [2:0] ST_D2H  = 3'd4;
    localparam logic [2:0] ST_D2L  = 3'd5;

    logic [2:0]                       r_state;
    logic [2:0]                       n_state;
    logic [gcne_pkg::ID_W-1:0]        r_rid;
    logic [gcne_pkg::SIDE_W-1:0]      r_side;
    logic                             r_three;
    logic [gcne_pkg::PLANE_W-1:0]     r_plane;
    logic                             r_inr;
    logic [gcne_pkg::ID_W-1:0]        r_rem;
    logic [gcne_pkg::SIDE_W-1:0]      r_q;
    logic [gcne_pkg::SIDE_W-1:0]      r_z;

    logic                             accept;
    logic                             div_lo;
    logic                             div_first;
    logic [gcne_pkg::PLANE_W-1:0]     divisor;
    logic [gcne_pkg::DIV_W-1:0]       rem_nx;
    logic [gcne_pkg::SIDE_W-1:0]      q_nx;
    logic [gcne_pkg::DIV_W-1:0]       div_trial;
    logic [2:0]                       div_k;
    logic [gcne_pkg::VOL_W-1:0]       limit;

    assign o_stall = (r_state != ST_IDLE);
    assign accept  = i_valid && !o_stall;

    // Divider: quotient fits SIDE_W bits for an in-range index, steps 6..3 then 2..0
    always_comb begin
        div_lo    = (r_state == ST_D1L) || (r_state == ST_D2L);
        div_first = (r_state == ST_D1H) || (r_state == ST_D1L);
        divisor   = (div_first && r_three) ? r_plane : gcne_pkg::PLANE_W'(r_side);
        rem_nx    = gcne_pkg::DIV_W'(r_rem);
        q_nx      = r_q;
        div_k     = 3'd0;
        div_trial = '0;
        for (int j = 0; j < 4; j++) begin
            if (!(div_lo && (j == 3))) begin
                div_k     = (div_lo ? 3'd2 : 3'd6) - 3'(j);
                div_trial = gcne_pkg::DIV_W'(divisor) << div_k;
                if (rem_nx >= div_trial) begin
                    rem_nx      = rem_nx - div_trial;
                    q_nx[div_k] = 1'b1;
                end
            end
        end
    end

    // Grid size bound for the range check
    assign limit = r_three ? (gcne_pkg::VOL_W'(r_plane) * gcne_pkg::VOL_W'(r_side))
                           : gcne_pkg::VOL_W'(r_plane);

    // Hand-off to the queue in the last divide step, while the queue is not full
    assign o_push = (((r_state == ST_D1L) && !r_three) || (r_state == ST_D2L)) && !i_full;

    always_comb begin
        o_job       = '0;
        o_job.rid   = r_rid;
        o_job.side  = r_side;
        o_job.plane = r_plane;
        o_job.three = r_three;
        o_job.inr   = r_inr;
        o_job.c0    = rem_nx[gcne_pkg::SIDE_W-1:0];
        o_job.c1    = q_nx;
        o_job.c2    = r_three ? r_z : '0;
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (accept) n_state = ST_PREP;
            ST_PREP: n_state = ST_D1H;
            ST_D1H:  n_state = ST_D1L;
            ST_D1L: begin
                if (r_three) n_state = ST_D2H;
                else if (!i_full) n_state = ST_IDLE;
            end
            ST_D2H:  n_state = ST_D2L;
            ST_D2L:  if (!i_full) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_rid   <= i_region_id;
                    r_side  <= i_cfg.side;
                    r_three <= i_cfg.three;
                    r_rem   <= i_region_id;
                    r_q     <= '0;
                end
            end
            ST_PREP: begin
                r_plane <= gcne_pkg::PLANE_W'(r_side) * gcne_pkg::PLANE_W'(r_side);
            end
            ST_D1H, ST_D2H: begin
                r_rem <= rem_nx[gcne_pkg::ID_W-1:0];
                r_q   <= q_nx;
                if (r_state == ST_D1H) begin
                    r_inr <= (gcne_pkg::VOL_W'(r_rid) < limit);
                end
            end
            ST_D1L: begin
                if (r_three) begin
                    r_z   <= q_nx;
                    r_rem <= rem_nx[gcne_pkg::ID_W-1:0];
                    r_q   <= '0;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: rtl/gcne_queue.sv
// Short job queue between the front and the back of the neighbor enumerator.
// Register array with read and write pointers. Depends on gcne_pkg.
module gcne_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  gcne_pkg::t_job  i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output gcne_pkg::t_job  o_data
);

    gcne_pkg::t_job                r_mem [gcne_pkg::QDEPTH];
    logic [gcne_pkg::QPTR_W-1:0]   r_wp;
    logic [gcne_pkg::QPTR_W-1:0]   r_rp;
    logic [gcne_pkg::QCNT_W-1:0]   r_cnt;

    assign o_full  = (r_cnt == gcne_pkg::QCNT_W'(gcne_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push |-> !o_full)) else $error("job pushed into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop |-> !o_empty)) else $error("job popped from empty queue");
`endif

endmodule

FILE: rtl/gcne_back.sv
// Back of the neighbor enumerator: builds the valid-direction mask of a job and
// emits one result per set bit, or one not-found result for an empty mask, through a registered output stage.
// Depends on gcne_pkg.
module gcne_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_empty,
    input  gcne_pkg::t_job              i_head,
    output logic                        o_pop,
    output logic                        o_valid,
    output logic [gcne_pkg::ID_W-1:0]   o_neighbor_id,
    output logic [gcne_pkg::DIR_W-1:0]  o_direction,
    output logic                        o_found,
    output logic                        o_last,
    input  logic                        i_stall
);

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    logic                               r_busy;
    logic [gcne_pkg::NUM_DIR-1:0]       r_mask;
    logic [gcne_pkg::ID_W-1:0]          r_rid;
    logic [gcne_pkg::SIDE_W-1:0]        r_side;
    logic [gcne_pkg::PLANE_W-1:0]       r_plane;
    logic                               r_three;
    logic                               r_out_valid;
    logic [gcne_pkg::ID_W-1:0]          r_nid;
    logic [gcne_pkg::DIR_W-1:0]         r_dir;
    logic                               r_found;
    logic                               r_last;

    logic [gcne_pkg::NUM_DIR-1:0]       head_mask;
    logic [1:0]                         h_axis;
    logic [gcne_pkg::SIDE_W-1:0]        h_coord;
    logic [gcne_pkg::VOL_W-1:0]         h_sum;
    logic                               h_ok;
    logic [gcne_pkg::DIR_W-1:0]         sel;
    logic [gcne_pkg::NUM_DIR-1:0]       sel_bit;
    logic [gcne_pkg::VOL_W-1:0]         sel_mag;
    logic [gcne_pkg::ID_W-1:0]          emit_id;
    logic                               emit_last;
    logic                               out_free;
    logic                               emit;
    logic                               done;
    logic                               load;

    // Axis of a direction: 2D order row-,row+,col-,col+; 3D order x-,x+,y-,y+,z-,z+
    function automatic logic [1:0] axis_of(input logic three,
                                           input logic [gcne_pkg::DIR_W-1:0] dir);
        logic [1:0] ax;
        ax = AX_X;
        if (three) begin
            case (dir[2:1])
                2'd0:    ax = AX_X;
                2'd1:    ax = AX_Y;
                default: ax = AX_Z;
            endcase
        end else begin
            ax = (dir[2:1] == 2'd0) ? AX_Y : AX_X;
        end
        return ax;
    endfunction

    // Index step along an axis
    function automatic logic [gcne_pkg::VOL_W-1:0] mag_of(
            input logic [1:0] ax,
            input logic [gcne_pkg::SIDE_W-1:0] side,
            input logic [gcne_pkg::PLANE_W-1:0] plane);
        logic [gcne_pkg::VOL_W-1:0] m;
        case (ax)
            AX_X:    m = gcne_pkg::VOL_W'(1);
            AX_Y:    m = gcne_pkg::VOL_W'(side);
            default: m = gcne_pkg::VOL_W'(plane);
        endcase
        return m;
    endfunction

    // Valid-direction mask of the queue head
    always_comb begin
        head_mask = '0;
        h_axis    = AX_X;
        h_coord   = '0;
        h_sum     = '0;
        h_ok      = 1'b0;
        for (int d = 0; d < gcne_pkg::NUM_DIR; d++) begin
            h_axis = axis_of(i_head.three, gcne_pkg::DIR_W'(d));
            case (h_axis)
                AX_X:    h_coord = i_head.c0;
                AX_Y:    h_coord = i_head.c1;
                default: h_coord = i_head.c2;
            endcase
            h_sum = gcne_pkg::VOL_W'(i_head.rid)
                  + mag_of(h_axis, i_head.side, i_head.plane);
            if (d % 2 == 1) begin
                h_ok = ({1'b0, h_coord} + 8'd1 < {1'b0, i_head.side})
                    && (h_sum[gcne_pkg::VOL_W-1:gcne_pkg::ID_W] == '0);
            end else begin
                h_ok = (h_coord != '0);
            end
            head_mask[d] = i_head.inr && (i_head.three || (d < 4)) && h_ok;
        end
    end

    // Lowest pending direction
    always_comb begin
        sel = '0;
        for (int d = gcne_pkg::NUM_DIR - 1; d >= 0; d--) begin
            if (r_mask[d]) sel = gcne_pkg::DIR_W'(d);
        end
        sel_bit   = gcne_pkg::NUM_DIR'(1) << sel;
        sel_mag   = mag_of(axis_of(r_three, sel), r_side, r_plane);
        emit_id   = sel[0] ? (r_rid + sel_mag[gcne_pkg::ID_W-1:0])
                           : (r_rid - sel_mag[gcne_pkg::ID_W-1:0]);
        emit_last = ((r_mask & ~sel_bit) == '0);
    end

    // Handshake between job register and output register
    assign out_free = !r_out_valid || !i_stall;
    assign emit     = r_busy && out_free;
    assign done     = emit && emit_last;
    assign load     = !i_empty && (!r_busy || done);
    assign o_pop    = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) r_busy <= 1'b1;
            else if (done) r_busy <= 1'b0;
            if (emit) r_out_valid <= 1'b1;
            else if (out_free) r_out_valid <= 1'b0;
        end
    end

    // Job register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_mask  <= head_mask;
            r_rid   <= i_head.rid;
            r_side  <= i_head.side;
            r_plane <= i_head.plane;
            r_three <= i_head.three;
        end else if (emit) begin
            r_mask  <= r_mask & ~sel_bit;
        end
    end

    // Output register; an empty mask gives the single not-found result
    always_ff @(posedge i_clk) begin
        if (emit) begin
            if (r_mask == '0) begin
                r_nid   <= '0;
                r_dir   <= '0;
                r_found <= 1'b0;
                r_last  <= 1'b1;
            end else begin
                r_nid   <= emit_id;
                r_dir   <= sel;
                r_found <= 1'b1;
                r_last  <= emit_last;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_neighbor_id = r_nid;
    assign o_direction   = r_dir;
    assign o_found       = r_found;
    assign o_last        = r_last;

`ifndef SYNTHESIS
    a_notfound_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found |-> o_last && (o_neighbor_id == '0) && (o_direction == '0)))
        else $error("not-found result must be a lone zero transaction");
`endif

endmodule

FILE: rtl/grid_cell_neighbor_enumerator_core.sv
// Grid cell neighbor enumerator, top level.
// Instantiates gcne_front, gcne_queue and gcne_back; depends on gcne_pkg.
//
// Usage:
//   Input channel i_valid/i_region_id/o_stall carries one linear cell index per
//   transaction. Output channel o_valid/o_neighbor_id/o_direction/o_found/o_last
//   with i_stall returns one transaction per face-adjacent in-grid neighbor,
//   in direction order, with o_last on the final one. An index beyond the grid
//   or a cell without neighbors gives one transaction with found low.
//   Registers: index 0 side_length (0 reads as 1, clamped to MAX_SIDE),
//   index 1 three_dim. Write them only while the block is idle.
// Operation:
//   The front takes each index through a plane multiply step and then, per
//   divide, a high and a low divide step: one divide in 2D, two in 3D. It takes
//   no new index until its job is pushed. The back emits one result per cycle
//   while the output is not stalled.
// Reset and stall:
//   Synchronous active-low reset empties the queue and output stage and loads
//   side_length 8, three_dim 0. A stalled output holds its transaction; the
//   back then stops, the queue fills, and the front raises o_stall.
module grid_cell_neighbor_enumerator_core #(
    parameter int MAX_SIDE = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [gcne_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [gcne_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                            i_valid,
    input  logic [gcne_pkg::ID_W-1:0]       i_region_id,
    output logic                            o_stall,
    output logic                            o_valid,
    output logic [gcne_pkg::ID_W-1:0]       o_neighbor_id,
    output logic [gcne_pkg::DIR_W-1:0]      o_direction,
    output logic                            o_found,
    output logic                            o_last,
    input  logic                            i_stall
);

    logic [gcne_pkg::SIDE_W-1:0] r_side_length;
    logic                        r_three_dim;
    gcne_pkg::t_cfg              cfg;
    logic                        q_push;
    logic                        q_full;
    logic                        q_pop;
    logic                        q_empty;
    gcne_pkg::t_job              q_in;
    gcne_pkg::t_job              q_head;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_length <= gcne_pkg::RST_SIDE_LENGTH;
            r_three_dim   <= gcne_pkg::RST_THREE_DIM;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                gcne_pkg::CFG_SIDE_LENGTH: r_side_length <= i_cfg_wdata;
                gcne_pkg::CFG_THREE_DIM:   r_three_dim   <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // Effective side length
    always_comb begin
        cfg.three = r_three_dim;
        if (r_side_length == '0) begin
            cfg.side = gcne_pkg::SIDE_W'(1);
        end else if (32'(r_side_length) > 32'(MAX_SIDE)) begin
            cfg.side = gcne_pkg::SIDE_W'(MAX_SIDE);
        end else begin
            cfg.side = r_side_length;
        end
    end

    gcne_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (i_valid),
        .i_region_id (i_region_id),
        .o_stall     (o_stall),
        .o_push      (q_push),
        .o_job       (q_in),
        .i_full      (q_full)
    );

    gcne_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_head)
    );

    gcne_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (q_empty),
        .i_head        (q_head),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .o_neighbor_id (o_neighbor_id),
        .o_direction   (o_direction),
        .o_found       (o_found),
        .o_last        (o_last),
        .i_stall       (i_stall)
    );

endmodule
